// ----- src/assert_macros.svh -----
// Shared assertion macros for the I2C bit engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/i2cmbe_pkg.sv -----
package i2cmbe_pkg;

    // Bits per transferred byte
    localparam int BYTE_BITS = 8;
    localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);

    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

    // Command codes
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_READ_ACK  = 3'd4;
    localparam logic [2:0] CMD_READ_NACK = 3'd5;
    localparam logic [2:0] CMD_WAIT_ACK  = 3'd6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Configuration reset values
    localparam logic [7:0] SETUP_RST   = 8'd4;
    localparam logic [7:0] HALF_RST    = 8'd2;
    localparam logic [7:0] TIMEOUT_RST = 8'd250;

    typedef struct packed {
        logic [7:0] setup_ticks;
        logic [7:0] half_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } result_t;

    // A hold of zero ticks counts as one
    function automatic logic [7:0] hold_ticks(input logic [7:0] ticks);
        return (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

endpackage

// ----- src/i2cmbe_item_if.sv -----
interface i2cmbe_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, cmd, tx_byte, sda_in, input ready);
    modport sink   (input valid, cmd, tx_byte, sda_in, output ready);
endinterface

// ----- src/i2cmbe_result_if.sv -----
interface i2cmbe_result_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;

    modport source (output valid, scl, sda_low, busy_res, done_res, rx_byte, ack_error,
                    input ready);
    modport sink   (input valid, scl, sda_low, busy_res, done_res, rx_byte, ack_error,
                    output ready);
endinterface

// ----- src/i2cmbe_cfg_if.sv -----
interface i2cmbe_cfg_if
    import i2cmbe_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/i2c_master_bit_engine.sv -----
// I2C master line sequencer driven by a time-base tick. Every accepted request
// on the item channel is one tick; it yields exactly one result on the result
// channel in the next clock, through a single output register. A new tick is
// accepted every clock as long as the result channel takes results, so the
// sustained rate is one tick per cycle; the output register is the only
// storage between the two channels. Commands (start, stop, write, read with
// ACK or NACK, wait for ACK) are taken only on ticks where busy_res was low.
// Configuration writes (setup_ticks, half_ticks, ack_timeout) are always
// accepted and must be made while the engine is idle.
`include "assert_macros.svh"

module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    i2cmbe_item_if.sink       item,
    i2cmbe_result_if.source   result,
    i2cmbe_cfg_if.sink        cfg
);

    cfg_t    cfg_reg;
    result_t res_comb;
    result_t res_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign step       = item.valid && item.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks <= SETUP_RST;
            cfg_reg.half_ticks  <= HALF_RST;
            cfg_reg.ack_timeout <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SETUP:   cfg_reg.setup_ticks <= cfg.data;
                CFG_HALF:    cfg_reg.half_ticks  <= cfg.data;
                CFG_TIMEOUT: cfg_reg.ack_timeout <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    i2cmbe_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cmd     (item.cmd),
        .tx_byte (item.tx_byte),
        .sda_in  (item.sda_in),
        .cfg     (cfg_reg),
        .res     (res_comb)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_comb;
    end

    assign result.valid     = out_valid_reg;
    assign result.scl       = res_reg.scl;
    assign result.sda_low   = res_reg.sda_low;
    assign result.busy_res  = res_reg.busy_res;
    assign result.done_res  = res_reg.done_res;
    assign result.rx_byte   = res_reg.rx_byte;
    assign result.ack_error = res_reg.ack_error;

    // Every accepted tick leaves a result pending
    `ASSERT_NEXT(a_tick_gives_result, clk, rst_n, step, out_valid_reg)
    // A done tick never reports busy
    `ASSERT_ALWAYS(a_done_not_busy, clk, rst_n,
        (!out_valid_reg || !(res_reg.done_res && res_reg.busy_res)))

endmodule

// ----- src/i2cmbe_seq.sv -----
`include "assert_macros.svh"

module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [2:0] cmd,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output result_t    res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C,
        PH_W_DATA,
        PH_W_HIGH,
        PH_W_LOW,
        PH_R_LOW,
        PH_R_HIGH,
        PH_A_SETUP,
        PH_A_HIGH,
        PH_WAIT,
        PH_WA_TAIL
    } phase_t;

    phase_t     phase_reg,   phase_next;
    logic [7:0] delay_reg,   delay_next;
    bit_cnt_t   bit_cnt_reg, bit_cnt_next;
    logic [7:0] shifter_reg, shifter_next;
    logic [7:0] wait_reg,    wait_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic       ack_mode_reg, ack_mode_next;
    logic [7:0] rx_reg,      rx_next;
    logic       err_reg,     err_next;
    logic       done;

    logic [7:0] delay_dec;
    logic [7:0] wait_inc;
    logic [7:0] rx_shift;
    bit_cnt_t   bit_inc;

    assign delay_dec = (delay_reg != 8'd0) ? delay_reg - 8'd1 : delay_reg;
    assign wait_inc  = (wait_reg != 8'hFF) ? wait_reg + 8'd1 : wait_reg;
    assign rx_shift  = {shifter_reg[6:0], sda_in};
    assign bit_inc   = bit_cnt_reg + bit_cnt_t'(1);

    // Next state for one tick
    always_comb
    begin
        phase_next    = phase_reg;
        delay_next    = delay_reg;
        bit_cnt_next  = bit_cnt_reg;
        shifter_next  = shifter_reg;
        wait_next     = wait_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_mode_next = ack_mode_reg;
        rx_next       = rx_reg;
        err_next      = err_reg;
        done          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd >= CMD_START && cmd <= CMD_WAIT_ACK)
                    err_next = 1'b0;
                case (cmd)
                    CMD_START:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PH_START_A;
                        delay_next = hold_ticks(cfg.setup_ticks);
                    end
                    CMD_STOP:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_A;
                        delay_next = hold_ticks(cfg.setup_ticks);
                    end
                    CMD_WRITE:
                    begin
                        scl_next     = 1'b0;
                        sda_next     = tx_byte[7];
                        shifter_next = {tx_byte[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_t'(1);
                        phase_next   = PH_W_DATA;
                        delay_next   = hold_ticks(cfg.half_ticks);
                    end
                    CMD_READ_ACK, CMD_READ_NACK:
                    begin
                        ack_mode_next = (cmd == CMD_READ_ACK);
                        scl_next      = 1'b0;
                        sda_next      = 1'b1;
                        bit_cnt_next  = '0;
                        shifter_next  = 8'd0;
                        phase_next    = PH_R_LOW;
                        delay_next    = hold_ticks(cfg.half_ticks);
                    end
                    CMD_WAIT_ACK:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        wait_next  = 8'd0;
                        phase_next = PH_WAIT;
                    end
                    default:
                    begin
                    end
                endcase
            end

            PH_WAIT:
            begin
                if (!sda_in)
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_WA_TAIL;
                    delay_next = hold_ticks(cfg.half_ticks);
                end
                else
                begin
                    wait_next = wait_inc;
                    // timeout: flag and issue a stop
                    if (wait_inc >= cfg.ack_timeout)
                    begin
                        err_next   = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_A;
                        delay_next = hold_ticks(cfg.setup_ticks);
                    end
                end
            end

            default:
            begin
                delay_next = delay_dec;
                if (delay_dec == 8'd0)
                begin
                    case (phase_reg)
                        PH_START_A:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_START_B;
                            delay_next = hold_ticks(cfg.setup_ticks);
                        end
                        PH_START_B:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_STOP_A:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_STOP_B;
                            delay_next = hold_ticks(cfg.setup_ticks);
                        end
                        PH_STOP_B:
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_STOP_C;
                            delay_next = hold_ticks(cfg.setup_ticks);
                        end
                        PH_W_DATA:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_W_HIGH;
                            delay_next = hold_ticks(cfg.half_ticks);
                        end
                        PH_W_HIGH:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_W_LOW;
                            delay_next = hold_ticks(cfg.half_ticks);
                        end
                        PH_W_LOW:
                        begin
                            if (bit_cnt_reg < bit_cnt_t'(BYTE_BITS))
                            begin
                                sda_next     = shifter_reg[7];
                                shifter_next = {shifter_reg[6:0], 1'b0};
                                bit_cnt_next = bit_inc;
                                phase_next   = PH_W_DATA;
                                delay_next   = hold_ticks(cfg.half_ticks);
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                        PH_R_LOW:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_R_HIGH;
                            delay_next = hold_ticks(cfg.half_ticks);
                        end
                        PH_R_HIGH:
                        begin
                            // sample SDA at the end of the high phase
                            shifter_next = rx_shift;
                            bit_cnt_next = bit_inc;
                            scl_next     = 1'b0;
                            if (bit_inc >= bit_cnt_t'(BYTE_BITS))
                            begin
                                rx_next    = rx_shift;
                                sda_next   = !ack_mode_reg;
                                phase_next = PH_A_SETUP;
                                delay_next = hold_ticks(cfg.setup_ticks);
                            end
                            else
                            begin
                                phase_next = PH_R_LOW;
                                delay_next = hold_ticks(cfg.half_ticks);
                            end
                        end
                        PH_A_SETUP:
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_A_HIGH;
                            delay_next = hold_ticks(cfg.half_ticks);
                        end
                        default:
                        begin
                            // end of stop, ack clock or wait-ack tail
                            if (phase_reg == PH_A_HIGH || phase_reg == PH_WA_TAIL)
                                scl_next = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    // Result seen after this tick
    assign res.scl       = scl_next;
    assign res.sda_low   = !sda_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.done_res  = done;
    assign res.rx_byte   = rx_next;
    assign res.ack_error = err_next;

    // Sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            delay_reg    <= 8'd0;
            bit_cnt_reg  <= '0;
            shifter_reg  <= 8'd0;
            wait_reg     <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_mode_reg <= 1'b0;
            rx_reg       <= 8'd0;
            err_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            delay_reg    <= delay_next;
            bit_cnt_reg  <= bit_cnt_next;
            shifter_reg  <= shifter_next;
            wait_reg     <= wait_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_mode_reg <= ack_mode_next;
            rx_reg       <= rx_next;
            err_reg      <= err_next;
        end
    end

    // Timed phases always hold a nonzero count
    `ASSERT_ALWAYS(a_timed_delay_nonzero, clk, rst_n,
        (phase_reg == PH_IDLE || phase_reg == PH_WAIT || delay_reg != 8'd0))
    `ASSERT_ALWAYS(a_bit_cnt_range, clk, rst_n, (bit_cnt_reg <= bit_cnt_t'(BYTE_BITS)))
    // Slave ack seen: SCL drops and the tail phase begins
    `ASSERT_NEXT(a_ack_seen, clk, rst_n, (step && phase_reg == PH_WAIT && !sda_in),
        (phase_reg == PH_WA_TAIL && !scl_reg))

endmodule
